// ===== design/edhj_pkg.sv =====
// Shared types and constants for the event dedup hash journal.
// No dependencies; used by edhj_hash and event_dedup_hash_journal.
`default_nettype none
package edhj_pkg;

  localparam int JOURNAL_DEPTH = 256;
  localparam int LOOKUP_SIZE   = 2 * JOURNAL_DEPTH;
  localparam int JW            = $clog2(JOURNAL_DEPTH);
  localparam int LW            = $clog2(LOOKUP_SIZE);
  localparam int FW            = $clog2(JOURNAL_DEPTH + 1);

  typedef logic [JW-1:0] jidx_t;
  typedef logic [JW:0]   jcnt_t;
  typedef logic [LW-1:0] lidx_t;
  typedef logic [LW:0]   lcnt_t;
  typedef logic [FW-1:0] fill_t;

  localparam logic [1:0] OP_SNAPSHOT = 2'd0;
  localparam logic [1:0] OP_EVENT    = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;

  localparam logic [2:0] CONT_INITIAL  = 3'd0;
  localparam logic [2:0] CONT_CONTIG   = 3'd1;
  localparam logic [2:0] CONT_GAP      = 3'd2;
  localparam logic [2:0] CONT_BASEJUMP = 3'd3;
  localparam logic [2:0] CONT_FULL     = 3'd4;
  localparam logic [2:0] CONT_DUP      = 3'd5;
  localparam logic [2:0] CONT_REWIND   = 3'd6;

  localparam logic [31:0] C_GOLD = 32'h9e3779b9;
  localparam logic [31:0] C_SN   = 32'h85ebca6b;
  localparam logic [31:0] C_EN   = 32'hc2b2ae35;
  localparam logic [31:0] C_EV   = 32'h27d4eb2f;
  localparam logic [31:0] C_FMIX = 32'h7feb352d;

  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] snapshot;
    logic [31:0] entity;
    logic [31:0] code;
  } tuple_t;

  typedef struct packed {
    tuple_t      tup;
    logic [31:0] serial;
  } jrn_word_t;

  typedef struct packed {
    logic [31:0] serial;
    jidx_t       slot_ref;
  } lk_word_t;

endpackage
`default_nettype wire

// ===== design/edhj_hash.sv =====
// Iterative tuple hash: one mixing step per cycle over a shared multiplier.
// Depends on edhj_pkg for the tuple type and mixing constants.
`default_nettype none
module edhj_hash (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire edhj_pkg::tuple_t tup_in,
  output logic                 done,
  output logic [31:0]          hash
);

  typedef enum logic [5:0] {
    HS_MUL0 = 6'b000001,
    HS_SN   = 6'b000010,
    HS_EN   = 6'b000100,
    HS_EV   = 6'b001000,
    HS_MUL1 = 6'b010000,
    HS_FIN  = 6'b100000
  } hstep_t;

  hstep_t           step_r;
  logic             run_r;
  logic             done_r;
  logic [31:0]      h_r;
  edhj_pkg::tuple_t t_r;

  logic [31:0] mix_in, mul_a, mul_b, prod, addend, combine;

  always_comb begin
    mix_in = h_r ^ (h_r >> 16);
    mul_a  = (step_r == HS_MUL0) ? t_r.epoch : mix_in;
    mul_b  = (step_r == HS_MUL0) ? edhj_pkg::C_GOLD : edhj_pkg::C_FMIX;
    prod   = mul_a * mul_b;
    case (step_r)
      HS_SN:   addend = t_r.snapshot + edhj_pkg::C_SN;
      HS_EN:   addend = t_r.entity + edhj_pkg::C_EN;
      default: addend = t_r.code + edhj_pkg::C_EV;
    endcase
    combine = h_r ^ (addend + (h_r << 6) + (h_r >> 2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= HS_MUL0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= HS_MUL0;
      end else if (run_r) begin
        case (step_r)
          HS_MUL0: step_r <= HS_SN;
          HS_SN:   step_r <= HS_EN;
          HS_EN:   step_r <= HS_EV;
          HS_EV:   step_r <= HS_MUL1;
          HS_MUL1: step_r <= HS_FIN;
          HS_FIN: begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
          default: step_r <= HS_MUL0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      t_r <= tup_in;
    end else if (run_r) begin
      case (step_r)
        HS_MUL0, HS_MUL1: h_r <= prod;
        HS_SN, HS_EN, HS_EV: h_r <= combine;
        default: h_r <= h_r ^ (h_r >> 15);
      endcase
    end
  end

  assign done = done_r;
  assign hash = h_r;

endmodule
`default_nettype wire

// ===== design/event_dedup_hash_journal.sv =====
// Top level: snapshot classifier, journal and lookup memories, probe sequencer.
// Depends on edhj_pkg and edhj_hash.
`default_nettype none
// A snapshot record or an unused operation is answered in the cycle after
// start, with busy staying low. An event with a nonzero code after the first
// snapshot is hashed first; each occupied lookup slot probed then passes
// ST_PRD, ST_PCHK and ST_JCHK, and the empty slot that ends the probe passes
// ST_PRD and ST_PCHK, since each probe reads the lookup memory and then the
// journal through their single read ports; a new tuple then passes ST_COMMIT
// and ST_WRITE to commit and write. A probe may walk all 512 slots. A timeline
// reset, and the reset after rst_n, run a clearing pass over the 512 lookup
// entries during which busy is high; after rst_n no result is given. When the
// 32-bit serial wraps, the event also waits for a lookup wipe and a rebuild
// that rehashes every live journal entry. Each item gives exactly one result
// beat on out_valid, which the receiver must take in that cycle.
module event_dedup_hash_journal (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic signed [31:0] in_snapshot_id,
  input  wire logic signed [31:0] in_baseline_id,
  input  wire logic [31:0]        in_entity_id,
  input  wire logic [31:0]        in_raw_event,
  output logic                    out_valid,
  output logic [2:0]              out_continuity,
  output logic [31:0]             out_epoch_now,
  output logic                    out_dispatch,
  output logic [8:0]              out_journal_fill,
  output logic [31:0]             out_accepted_total,
  output logic [31:0]             out_duplicate_total
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_CLEAR    = 13'b0000000000010,
    ST_HASH     = 13'b0000000000100,
    ST_PRD      = 13'b0000000001000,
    ST_PCHK     = 13'b0000000010000,
    ST_JCHK     = 13'b0000000100000,
    ST_COMMIT   = 13'b0000001000000,
    ST_WRITE    = 13'b0000010000000,
    ST_REB_RD   = 13'b0000100000000,
    ST_REB_CHK  = 13'b0001000000000,
    ST_REB_HASH = 13'b0010000000000,
    ST_FE_RD    = 13'b0100000000000,
    ST_FE_CHK   = 13'b1000000000000
  } state_t;

  // memories
  edhj_pkg::jrn_word_t jrn_mem [edhj_pkg::JOURNAL_DEPTH];
  edhj_pkg::lk_word_t  lk_mem  [edhj_pkg::LOOKUP_SIZE];
  edhj_pkg::jrn_word_t jrn_rd_r, jrn_wdata;
  edhj_pkg::lk_word_t  lk_rd_r, lk_wdata;
  edhj_pkg::jidx_t     jrn_raddr, jrn_waddr;
  edhj_pkg::lidx_t     lk_waddr;
  logic                jrn_we, lk_we;

  state_t              state_r, state_nxt;
  logic [31:0]         epoch_r, epoch_nxt;
  logic                have_r, have_nxt;
  logic [31:0]         last_r, last_nxt;
  edhj_pkg::jidx_t     wp_r, wp_nxt;
  edhj_pkg::fill_t     fill_r, fill_nxt;
  logic [31:0]         serial_r, serial_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         dup_r, dup_nxt;
  edhj_pkg::tuple_t    tup_r, tup_nxt;
  edhj_pkg::lidx_t     idx_r, idx_nxt;
  edhj_pkg::lidx_t     home_r, home_nxt;
  edhj_pkg::lcnt_t     n_r, n_nxt;
  logic                found_r, found_nxt;
  edhj_pkg::lidx_t     free_r, free_nxt;
  logic [31:0]         lks_r, lks_nxt;
  edhj_pkg::lidx_t     clr_r, clr_nxt;
  logic                clr_full_r, clr_full_nxt;
  logic                clr_out_r, clr_out_nxt;
  edhj_pkg::jcnt_t     j_r, j_nxt;
  logic [31:0]         reb_ser_r, reb_ser_nxt;
  logic                fe_home_r, fe_home_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_cont_r, out_cont_nxt;
  logic                out_disp_r, out_disp_nxt;

  logic                hash_go, hash_done;
  logic [31:0]         hash_val;
  edhj_pkg::tuple_t    hash_tup;
  edhj_pkg::lidx_t     hash_slot, idx_next;

  logic                accept;
  logic [2:0]          cont;
  logic [31:0]         epoch_first;
  logic [31:0]         ser_inc;
  logic                found_now, live;
  edhj_pkg::lidx_t     free_now;

  function automatic logic [31:0] bump(input logic [31:0] e);
    logic [31:0] s;
    s = e + 32'd1;
    return (s == 32'd0) ? 32'd1 : s;
  endfunction

  edhj_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (hash_go),
    .tup_in (hash_tup),
    .done   (hash_done),
    .hash   (hash_val)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign hash_slot = edhj_pkg::lidx_t'(hash_val % edhj_pkg::LOOKUP_SIZE);
  assign idx_next  = (idx_r == edhj_pkg::lidx_t'(edhj_pkg::LOOKUP_SIZE - 1)) ?
                     '0 : idx_r + 1'b1;
  assign ser_inc   = serial_r + 32'd1;
  assign live      = (jrn_rd_r.serial == lks_r);

  // snapshot continuity against the last recorded id
  always_comb begin
    logic signed [31:0] prev;
    prev = $signed(last_r);
    if (!have_r)                                    cont = edhj_pkg::CONT_INITIAL;
    else if (in_snapshot_id == prev)                cont = edhj_pkg::CONT_DUP;
    else if (in_snapshot_id < prev)                 cont = edhj_pkg::CONT_REWIND;
    else if (in_snapshot_id != prev + 32'sd1)       cont = edhj_pkg::CONT_GAP;
    else if (in_baseline_id <= 32'sd0)              cont = edhj_pkg::CONT_FULL;
    else if (in_baseline_id != prev)                cont = edhj_pkg::CONT_BASEJUMP;
    else                                            cont = edhj_pkg::CONT_CONTIG;
  end

  assign epoch_first = (epoch_r == 32'd0) ? 32'd1 : epoch_r;

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    have_nxt      = have_r;
    last_nxt      = last_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    serial_nxt    = serial_r;
    acc_nxt       = acc_r;
    dup_nxt       = dup_r;
    tup_nxt       = tup_r;
    idx_nxt       = idx_r;
    home_nxt      = home_r;
    n_nxt         = n_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    lks_nxt       = lks_r;
    clr_nxt       = clr_r;
    clr_full_nxt  = clr_full_r;
    clr_out_nxt   = clr_out_r;
    j_nxt         = j_r;
    reb_ser_nxt   = reb_ser_r;
    fe_home_nxt   = fe_home_r;
    out_valid_nxt = 1'b0;
    out_cont_nxt  = edhj_pkg::CONT_INITIAL;
    out_disp_nxt  = 1'b0;
    hash_go       = 1'b0;
    hash_tup      = '{epoch: epoch_r, snapshot: last_r, entity: in_entity_id,
                      code: in_raw_event};
    jrn_raddr     = j_r[edhj_pkg::JW-1:0];
    jrn_we        = 1'b0;
    jrn_waddr     = wp_r;
    jrn_wdata     = '{tup: tup_r, serial: serial_r};
    lk_we         = 1'b0;
    lk_waddr      = free_r;
    lk_wdata      = '{serial: serial_r, slot_ref: wp_r};
    found_now     = found_r;
    free_now      = free_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            edhj_pkg::OP_SNAPSHOT: begin
              epoch_nxt     = (cont == edhj_pkg::CONT_REWIND) ? bump(epoch_first)
                                                               : epoch_first;
              last_nxt      = in_snapshot_id;
              have_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
              out_cont_nxt  = cont;
            end
            edhj_pkg::OP_EVENT: begin
              if (!have_r || in_raw_event == 32'd0) begin
                out_valid_nxt = 1'b1;
                out_disp_nxt  = 1'b1;
              end else begin
                tup_nxt   = hash_tup;
                hash_go   = 1'b1;
                state_nxt = ST_HASH;
              end
            end
            edhj_pkg::OP_RESET: begin
              epoch_nxt    = bump(epoch_r);
              have_nxt     = 1'b0;
              last_nxt     = '0;
              wp_nxt       = '0;
              fill_nxt     = '0;
              serial_nxt   = '0;
              acc_nxt      = '0;
              dup_nxt      = '0;
              clr_nxt      = '0;
              clr_full_nxt = 1'b1;
              clr_out_nxt  = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r;
        lk_wdata = '0;
        if (clr_full_r && (32'(clr_r) < 32'(edhj_pkg::JOURNAL_DEPTH))) begin
          jrn_we    = 1'b1;
          jrn_waddr = clr_r[edhj_pkg::JW-1:0];
          jrn_wdata = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == edhj_pkg::lidx_t'(edhj_pkg::LOOKUP_SIZE - 1)) begin
          if (clr_full_r) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = clr_out_r;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_REB_RD;
          end
        end
      end

      ST_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_slot;
          home_nxt  = hash_slot;
          n_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = ST_PRD;
        end
      end

      ST_PRD: state_nxt = ST_PCHK;

      ST_PCHK, ST_JCHK: begin
        jrn_raddr = lk_rd_r.slot_ref;
        if (state_r == ST_PCHK && lk_rd_r.serial == 32'd0) begin
          // empty slot ends the probe
          if (!found_r) free_nxt = idx_r;
          state_nxt = ST_COMMIT;
        end else if (state_r == ST_PCHK &&
                     32'(lk_rd_r.slot_ref) < 32'(edhj_pkg::JOURNAL_DEPTH)) begin
          lks_nxt   = lk_rd_r.serial;
          state_nxt = ST_JCHK;
        end else if (state_r == ST_JCHK && live && jrn_rd_r.tup == tup_r) begin
          dup_nxt       = dup_r + 32'd1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // no match: remember the first dead slot, advance
          if (!found_r && !(state_r == ST_JCHK && live)) begin
            found_now = 1'b1;
            free_now  = idx_r;
          end
          found_nxt = found_now;
          free_nxt  = free_now;
          n_nxt     = n_r + 1'b1;
          if (32'(n_r) + 32'd1 == 32'(edhj_pkg::LOOKUP_SIZE)) begin
            if (found_now) begin
              state_nxt = ST_COMMIT;
            end else begin
              dup_nxt       = dup_r + 32'd1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else begin
            idx_nxt   = idx_next;
            state_nxt = ST_PRD;
          end
        end
      end

      ST_COMMIT: begin
        if (ser_inc == 32'd0) begin
          // serial wrap: wipe lookup, then rebuild from the journal
          serial_nxt   = 32'd1;
          clr_nxt      = '0;
          clr_full_nxt = 1'b0;
          clr_out_nxt  = 1'b0;
          state_nxt    = ST_CLEAR;
        end else begin
          serial_nxt = ser_inc;
          state_nxt  = ST_WRITE;
        end
      end

      ST_WRITE: begin
        jrn_we        = 1'b1;
        lk_we         = 1'b1;
        wp_nxt        = (wp_r == edhj_pkg::jidx_t'(edhj_pkg::JOURNAL_DEPTH - 1)) ?
                        '0 : wp_r + 1'b1;
        if (32'(fill_r) < 32'(edhj_pkg::JOURNAL_DEPTH)) fill_nxt = fill_r + 1'b1;
        acc_nxt       = acc_r + 32'd1;
        out_valid_nxt = 1'b1;
        out_disp_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_REB_RD: begin
        if (32'(j_r) == 32'(edhj_pkg::JOURNAL_DEPTH)) begin
          idx_nxt     = home_r;
          fe_home_nxt = 1'b1;
          state_nxt   = ST_FE_RD;
        end else begin
          state_nxt = ST_REB_CHK;
        end
      end

      ST_REB_CHK: begin
        if (jrn_rd_r.serial == 32'd0) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_REB_RD;
        end else begin
          reb_ser_nxt = jrn_rd_r.serial;
          hash_tup    = jrn_rd_r.tup;
          hash_go     = 1'b1;
          state_nxt   = ST_REB_HASH;
        end
      end

      ST_REB_HASH: begin
        if (hash_done) begin
          idx_nxt     = hash_slot;
          fe_home_nxt = 1'b0;
          state_nxt   = ST_FE_RD;
        end
      end

      ST_FE_RD: state_nxt = ST_FE_CHK;

      ST_FE_CHK: begin
        if (lk_rd_r.serial == 32'd0) begin
          if (fe_home_r) begin
            free_nxt  = idx_r;
            state_nxt = ST_WRITE;
          end else begin
            lk_we     = 1'b1;
            lk_waddr  = idx_r;
            lk_wdata  = '{serial: reb_ser_r, slot_ref: j_r[edhj_pkg::JW-1:0]};
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_REB_RD;
          end
        end else begin
          idx_nxt   = idx_next;
          state_nxt = ST_FE_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // one write port and one read port per memory; read data from an entry in
  // the cycle it is written is never used, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (jrn_we) jrn_mem[jrn_waddr] <= jrn_wdata;
    jrn_rd_r <= jrn_mem[jrn_raddr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    lk_rd_r <= lk_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= '0;
      have_r      <= 1'b0;
      last_r      <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      serial_r    <= '0;
      acc_r       <= '0;
      dup_r       <= '0;
      clr_r       <= '0;
      clr_full_r  <= 1'b1;
      clr_out_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      have_r      <= have_nxt;
      last_r      <= last_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      serial_r    <= serial_nxt;
      acc_r       <= acc_nxt;
      dup_r       <= dup_nxt;
      clr_r       <= clr_nxt;
      clr_full_r  <= clr_full_nxt;
      clr_out_r   <= clr_out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tup_r      <= tup_nxt;
    idx_r      <= idx_nxt;
    home_r     <= home_nxt;
    n_r        <= n_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    lks_r      <= lks_nxt;
    j_r        <= j_nxt;
    reb_ser_r  <= reb_ser_nxt;
    fe_home_r  <= fe_home_nxt;
    out_cont_r <= out_cont_nxt;
    out_disp_r <= out_disp_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_continuity      = out_cont_r;
  assign out_epoch_now       = epoch_r;
  assign out_dispatch        = out_disp_r;
  assign out_journal_fill    = 9'(fill_r);
  assign out_accepted_total  = acc_r;
  assign out_duplicate_total = dup_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(edhj_pkg::JOURNAL_DEPTH))
    else $error("journal fill above depth");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> epoch_r != 32'd0)
    else $error("zero epoch after a snapshot");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_operation == edhj_pkg::OP_RESET |=> state_r == ST_CLEAR && fill_r == '0)
    else $error("timeline reset did not start clearing");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_disp_r && out_cont_r != edhj_pkg::CONT_INITIAL))
    else $error("dispatch and continuity both set");

endmodule
`default_nettype wire

// ===== tb/event_dedup_hash_journal_tb.sv =====
// Self-checking testbench for event_dedup_hash_journal: snapshot continuity,
// event dedup through the hashed journal, timeline resets. Depends on edhj_pkg.
`default_nettype none
module event_dedup_hash_journal_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  continuity;
    logic [31:0] epoch_now;
    logic        dispatch;
    logic        dropped;
    logic [8:0]  fill;
    logic [31:0] accepted;
    logic [31:0] duplicates;
  } verdict_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_operation;
  logic signed [31:0] in_snapshot_id;
  logic signed [31:0] in_baseline_id;
  logic [31:0]        in_entity_id;
  logic [31:0]        in_raw_event;
  logic               out_valid;
  logic [2:0]         out_continuity;
  logic [31:0]        out_epoch_now;
  logic               out_dispatch;
  logic [8:0]         out_journal_fill;
  logic [31:0]        out_accepted_total;
  logic [31:0]        out_duplicate_total;

  event_dedup_hash_journal u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_snapshot_id(in_snapshot_id),
    .in_baseline_id(in_baseline_id), .in_entity_id(in_entity_id),
    .in_raw_event(in_raw_event), .out_valid(out_valid),
    .out_continuity(out_continuity), .out_epoch_now(out_epoch_now),
    .out_dispatch(out_dispatch), .out_journal_fill(out_journal_fill),
    .out_accepted_total(out_accepted_total),
    .out_duplicate_total(out_duplicate_total)
  );

  // shadow state of the block
  logic [31:0] sh_epoch;
  logic        sh_have_snap;
  logic [31:0] sh_last_snap;
  logic [31:0] jn_epoch[edhj_pkg::JOURNAL_DEPTH];
  logic [31:0] jn_snap[edhj_pkg::JOURNAL_DEPTH];
  logic [31:0] jn_entity[edhj_pkg::JOURNAL_DEPTH];
  logic [31:0] jn_code[edhj_pkg::JOURNAL_DEPTH];
  logic [31:0] jn_serial[edhj_pkg::JOURNAL_DEPTH];
  logic [31:0] lk_serial[edhj_pkg::LOOKUP_SIZE];
  int unsigned lk_ref[edhj_pkg::LOOKUP_SIZE];
  int unsigned sh_wptr;
  int unsigned sh_fill;
  logic [31:0] sh_next_serial;
  logic [31:0] sh_accepted;
  logic [31:0] sh_dups;

  verdict_t    verdict_q[$];
  int          errors;
  int          beats_sent;
  int          beats_checked;
  int          dispatched_seen;
  int          suppressed_seen;
  bit          gapless;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] tuple_hash(logic [31:0] ep, logic [31:0] sn,
                                             logic [31:0] en, logic [31:0] ev);
    logic [31:0] h;
    h = ep * edhj_pkg::C_GOLD;
    h ^= sn + edhj_pkg::C_SN + (h << 6) + (h >> 2);
    h ^= en + edhj_pkg::C_EN + (h << 6) + (h >> 2);
    h ^= ev + edhj_pkg::C_EV + (h << 6) + (h >> 2);
    h ^= h >> 16;
    h *= edhj_pkg::C_FMIX;
    h ^= h >> 15;
    return h;
  endfunction

  function automatic int unsigned first_free_slot(int unsigned from);
    int unsigned idx;
    idx = from;
    for (int n = 0; n < edhj_pkg::LOOKUP_SIZE; n++) begin
      if (lk_serial[idx] == 0) break;
      idx = (idx + 1) % edhj_pkg::LOOKUP_SIZE;
    end
    return idx;
  endfunction

  function automatic void clear_timeline();
    sh_have_snap = 0;
    sh_last_snap = '0;
    for (int i = 0; i < edhj_pkg::JOURNAL_DEPTH; i++) jn_serial[i] = '0;
    for (int i = 0; i < edhj_pkg::LOOKUP_SIZE; i++) lk_serial[i] = '0;
    sh_wptr = 0;
    sh_fill = 0;
    sh_next_serial = '0;
    sh_accepted = '0;
    sh_dups = '0;
  endfunction

  // probe for the tuple; journal it if new, return 0 when it must be dropped
  function automatic bit journal_insert(logic [31:0] ep, logic [31:0] sn,
                                        logic [31:0] en, logic [31:0] ev);
    int unsigned home, idx, free_slot, r;
    bit found, live;
    home = tuple_hash(ep, sn, en, ev) % edhj_pkg::LOOKUP_SIZE;
    idx = home;
    found = 0;
    free_slot = 0;
    for (int n = 0; n < edhj_pkg::LOOKUP_SIZE; n++) begin
      if (lk_serial[idx] == 0) begin
        if (!found) begin
          found = 1;
          free_slot = idx;
        end
        break;
      end
      r = lk_ref[idx];
      live = r < edhj_pkg::JOURNAL_DEPTH && jn_serial[r] == lk_serial[idx];
      if (!live) begin
        if (!found) begin
          found = 1;
          free_slot = idx;
        end
      end else if (jn_epoch[r] == ep && jn_snap[r] == sn &&
                   jn_entity[r] == en && jn_code[r] == ev) begin
        return 0;
      end
      idx = (idx + 1) % edhj_pkg::LOOKUP_SIZE;
    end
    if (!found) return 0;
    sh_next_serial++;
    if (sh_next_serial == 0) begin
      // serial wrapped: rebuild the lookup table from the journal
      for (int i = 0; i < edhj_pkg::LOOKUP_SIZE; i++) lk_serial[i] = '0;
      sh_next_serial = 1;
      for (int j = 0; j < edhj_pkg::JOURNAL_DEPTH; j++) begin
        if (jn_serial[j] != 0) begin
          idx = first_free_slot(tuple_hash(jn_epoch[j], jn_snap[j], jn_entity[j],
                                           jn_code[j]) % edhj_pkg::LOOKUP_SIZE);
          lk_serial[idx] = jn_serial[j];
          lk_ref[idx] = j;
        end
      end
      free_slot = first_free_slot(home);
    end
    jn_epoch[sh_wptr] = ep;
    jn_snap[sh_wptr] = sn;
    jn_entity[sh_wptr] = en;
    jn_code[sh_wptr] = ev;
    jn_serial[sh_wptr] = sh_next_serial;
    lk_serial[free_slot] = sh_next_serial;
    lk_ref[free_slot] = sh_wptr;
    sh_wptr = (sh_wptr + 1 == edhj_pkg::JOURNAL_DEPTH) ? 0 : sh_wptr + 1;
    if (sh_fill < edhj_pkg::JOURNAL_DEPTH) sh_fill++;
    return 1;
  endfunction

  function automatic logic [31:0] advance_epoch(logic [31:0] e);
    return (e + 1 == 0) ? 32'd1 : e + 1;
  endfunction

  function automatic logic [2:0] classify(logic [31:0] id, logic [31:0] base);
    longint prev, sid, sbase;
    if (!sh_have_snap) return edhj_pkg::CONT_INITIAL;
    prev = longint'($signed(sh_last_snap));
    sid = longint'($signed(id));
    sbase = longint'($signed(base));
    if (sid == prev) return edhj_pkg::CONT_DUP;
    if (sid < prev) return edhj_pkg::CONT_REWIND;
    if (sid != prev + 1) return edhj_pkg::CONT_GAP;
    if (sbase <= 0) return edhj_pkg::CONT_FULL;
    if (sbase != prev) return edhj_pkg::CONT_BASEJUMP;
    return edhj_pkg::CONT_CONTIG;
  endfunction

  function automatic verdict_t predict_item(logic [1:0] op, logic [31:0] sid,
                                            logic [31:0] bid, logic [31:0] en,
                                            logic [31:0] ev);
    verdict_t v;
    logic [31:0] e;
    v.continuity = edhj_pkg::CONT_INITIAL;
    v.dispatch = 0;
    v.dropped = 0;
    case (op)
      edhj_pkg::OP_SNAPSHOT: begin
        if (sh_epoch == 0) sh_epoch = advance_epoch(sh_epoch);
        v.continuity = classify(sid, bid);
        if (v.continuity == edhj_pkg::CONT_REWIND) sh_epoch = advance_epoch(sh_epoch);
        sh_last_snap = sid;
        sh_have_snap = 1;
      end
      edhj_pkg::OP_EVENT: begin
        if (!sh_have_snap || ev == 0) begin
          v.dispatch = 1;
        end else if (journal_insert(sh_epoch, sh_last_snap, en, ev)) begin
          sh_accepted++;
          v.dispatch = 1;
        end else begin
          sh_dups++;
          v.dropped = 1;
        end
      end
      edhj_pkg::OP_RESET: begin
        e = advance_epoch(sh_epoch);
        clear_timeline();
        sh_epoch = e;
      end
      default: ;
    endcase
    v.epoch_now = sh_epoch;
    v.fill = sh_fill[8:0];
    v.accepted = sh_accepted;
    v.duplicates = sh_dups;
    return v;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("MISMATCH beat %0d %s: expected %h got %h", beats_checked, field, want, got);
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 1);
      end else begin
        v = verdict_q.pop_front();
        if (out_continuity !== v.continuity)
          report_mismatch("continuity", v.continuity, out_continuity);
        if (out_epoch_now !== v.epoch_now)
          report_mismatch("epoch_now", v.epoch_now, out_epoch_now);
        if (out_dispatch !== v.dispatch)
          report_mismatch("dispatch", v.dispatch, out_dispatch);
        if (out_journal_fill !== v.fill)
          report_mismatch("journal_fill", v.fill, out_journal_fill);
        if (out_accepted_total !== v.accepted)
          report_mismatch("accepted_total", v.accepted, out_accepted_total);
        if (out_duplicate_total !== v.duplicates)
          report_mismatch("duplicate_total", v.duplicates, out_duplicate_total);
        if (v.dispatch) dispatched_seen++;
        else if (v.dropped) suppressed_seen++;
      end
      beats_checked++;
    end
  end

  // drive one item, hold start until accepted, then idle a random while unless gapless
  task automatic send_item(logic [1:0] op, logic [31:0] sid, logic [31:0] bid,
                           logic [31:0] en, logic [31:0] ev);
    int gap;
    start <= 1'b1;
    in_operation <= op;
    in_snapshot_id <= sid;
    in_baseline_id <= bid;
    in_entity_id <= en;
    in_raw_event <= ev;
    do @(posedge clk); while (busy);
    verdict_q.push_back(predict_item(op, sid, bid, en, ev));
    beats_sent++;
    gap = gapless ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_snapshot(logic [31:0] sid, logic [31:0] bid);
    send_item(edhj_pkg::OP_SNAPSHOT, sid, bid, $urandom, $urandom);
  endtask

  task automatic send_event(logic [31:0] en, logic [31:0] ev);
    send_item(edhj_pkg::OP_EVENT, $urandom, $urandom, en, ev);
  endtask

  task automatic test_snapshot_continuity();
    send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    send_event(32'h1, 32'h5);                // no snapshot yet
    send_snapshot(32'd10, 32'd0);            // first snapshot bumps zero epoch
    send_snapshot(32'd11, 32'd10);           // contiguous
    send_snapshot(32'd11, 32'd10);           // same id again
    send_snapshot(32'd12, 32'd0);            // full
    send_snapshot(32'd13, 32'hffffffff);     // full, negative baseline
    send_snapshot(32'd14, 32'd7);            // baseline jump
    send_snapshot(32'd20, 32'd19);           // gap
    send_snapshot(32'd3, 32'd2);             // rewind
    send_snapshot(32'h7fffffff, 32'h7ffffffe);
    send_snapshot(32'h80000000, 32'h7fffffff); // most negative id is a rewind
    send_snapshot(32'h80000001, 32'h80000000);
  endtask

  task automatic test_event_dedup();
    send_event(32'h0, 32'h0);                // zero code skips the journal
    send_event(32'hffffffff, 32'hffffffff);
    send_event(32'hffffffff, 32'hffffffff);  // duplicate
    send_event(32'h0, 32'h1);
    send_event(32'h0, 32'h1);
    send_item(OP_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_snapshot(32'h80000002, 32'h80000001);
    send_event(32'h0, 32'h1);                // new snapshot, new tuple
    send_item(edhj_pkg::OP_RESET, $urandom, $urandom, $urandom, $urandom);
    send_event(32'h0, 32'h1);                // no snapshot after reset
  endtask

  // push past the journal depth so the ring wraps and old tuples are evicted
  task automatic test_journal_wrap();
    logic [31:0] base_en;
    gapless = 1;
    base_en = $urandom;
    send_snapshot(32'd100, 32'd99);
    for (int i = 0; i < 300; i++) send_event(base_en + i, 32'h77);
    gapless = 0;
    for (int i = 0; i < 40; i++) send_event(base_en + $urandom_range(0, 299), 32'h77);
  endtask

  task automatic test_random_traffic(int count);
    logic [31:0] sid, en, ev;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) gapless = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        en = (pick < 45) ? 32'h1000 + $urandom_range(0, 7) : $urandom;
        ev = (pick < 45) ? $urandom_range(0, 5) : $urandom;
        send_event(en, ev);
      end else if (pick < 88) begin
        sid = sh_last_snap + 1;
        case ($urandom_range(0, 7))
          0: send_snapshot($urandom, $urandom);
          1: send_snapshot(sh_last_snap - $urandom_range(0, 3), $urandom);
          2: send_snapshot(sid, 32'h0 - $urandom_range(0, 2));
          3: send_snapshot(sid + $urandom_range(1, 4), sh_last_snap);
          4: send_snapshot(sid, sh_last_snap - $urandom_range(1, 3));
          default: send_snapshot(sid, sh_last_snap);
        endcase
      end else if (pick < 92) begin
        send_item(edhj_pkg::OP_RESET, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
    end
    gapless = 0;
  endtask

  initial begin
    int waited;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    dispatched_seen = 0;
    suppressed_seen = 0;
    gapless = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = edhj_pkg::OP_SNAPSHOT;
    in_snapshot_id = '0;
    in_baseline_id = '0;
    in_entity_id = '0;
    in_raw_event = '0;
    sh_epoch = '0;
    clear_timeline();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_snapshot_continuity();
    test_event_dedup();
    test_journal_wrap();
    test_random_traffic(1000);

    start <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (verdict_q.size() != 0) begin
      errors++;
      $display("%0d expected beats never arrived", verdict_q.size());
    end
    $display("Sent %0d items, checked %0d beats: %0d dispatched, %0d dropped events.",
             beats_sent, beats_checked, dispatched_seen, suppressed_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
